// ===== rtl/core/mbf_pkg.sv =====
// ----------------------------------------------------------------------------
// mbf_pkg
// shared constants and types of the maximal bit-set filter
// ----------------------------------------------------------------------------
`default_nettype none

package mbf_pkg;

    // default geometry
    localparam int SET_WIDTH_DEF   = 64;
    localparam int TABLE_DEPTH_DEF = 64;

    // fixed field widths of the ports
    localparam int CAND_W    = 64;
    localparam int WINDOW_W  = 7;
    localparam int COUNT_W   = 7;
    localparam int OUTCOME_W = 2;

    // outcome codes
    localparam logic [OUTCOME_W-1:0] OUTCOME_SUBSET = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_APPEND = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_FULL   = 2'd2;

    // flags from the subset compare unit
    typedef struct packed {
        logic cand_in_entry;   // candidate is a subset of the stored entry
        logic entry_in_cand;   // stored entry is a subset of the candidate
    } subset_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/mbf_subset_unit.sv =====
// ----------------------------------------------------------------------------
// mbf_subset_unit
// shared compare unit: subset relation both ways between two bit sets
// ----------------------------------------------------------------------------
`default_nettype none

module mbf_subset_unit #(
    parameter int SET_WIDTH = mbf_pkg::SET_WIDTH_DEF
) (
    input  wire logic [SET_WIDTH-1:0] cand,
    input  wire logic [SET_WIDTH-1:0] entry,
    output mbf_pkg::subset_flags_t    flags
);

    assign flags.cand_in_entry = ((cand & ~entry) == '0);
    assign flags.entry_in_cand = ((entry & ~cand) == '0);

endmodule

`default_nettype wire

// ===== rtl/core/mbf_table.sv =====
// ----------------------------------------------------------------------------
// mbf_table
// set table storage: one write port, one read port with registered data
// ----------------------------------------------------------------------------
`default_nettype none

module mbf_table #(
    parameter int SET_WIDTH   = mbf_pkg::SET_WIDTH_DEF,
    parameter int TABLE_DEPTH = mbf_pkg::TABLE_DEPTH_DEF,
    localparam int ADDR_W     = $clog2(TABLE_DEPTH)
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_W-1:0]    wr_addr,
    input  wire logic [SET_WIDTH-1:0] wr_data,
    input  wire logic [ADDR_W-1:0]    rd_addr,
    output logic      [SET_WIDTH-1:0] rd_data
);

    logic [SET_WIDTH-1:0] mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/maximal_bitset_filter_core.sv =====
// ----------------------------------------------------------------------------
// maximal_bitset_filter_core
// keeps a table of mutually non-subset bit sets and filters candidates
// ----------------------------------------------------------------------------
// A transfer is taken when start is high and busy is low; busy then stays
// high until the cycle in which the single result is shown. The result
// appears on outcome, removed_count and entry_count for exactly one cycle
// with done high, and the receiver cannot stall it, so it must capture it on
// that edge. The window is walked from its top entry down, one stored set at
// a time through a single subset compare unit fed by the table's read port:
// each entry visited passes through ST_LOOP, which issues its read, and
// ST_COMPARE, which runs the compare; each removal adds ST_MOVE, after a
// second read that fetches the last entry, and an item that is not dropped
// ends in ST_APPEND, which appends it or flags full and shows the result.
// The table needs no clearing after reset: only entries below the count
// are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module maximal_bitset_filter_core #(
    parameter int SET_WIDTH   = mbf_pkg::SET_WIDTH_DEF,
    parameter int TABLE_DEPTH = mbf_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // command side
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [mbf_pkg::CAND_W-1:0]     candidate_set,
    input  wire logic [mbf_pkg::WINDOW_W-1:0]   window_start,
    input  wire logic [mbf_pkg::WINDOW_W-1:0]   window_end,
    // result side
    output logic                                done,
    output logic [mbf_pkg::OUTCOME_W-1:0]       outcome,
    output logic [mbf_pkg::COUNT_W-1:0]         removed_count,
    output logic [mbf_pkg::COUNT_W-1:0]         entry_count
);

    // widths: the count holds 0..TABLE_DEPTH, compares run at the wider of
    // the count and the 7-bit window fields
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > mbf_pkg::WINDOW_W) ? CNT_W : mbf_pkg::WINDOW_W;
    localparam int OUT_W  = (CMP_W > mbf_pkg::COUNT_W) ? CMP_W : mbf_pkg::COUNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOP,      // decide on the next window entry, issue its read
        ST_COMPARE,   // entry data back, run the subset compare
        ST_MOVE,      // last entry back, write it into the removed slot
        ST_APPEND     // append the candidate or flag full
    } state_t;

    state_t                          state_reg, state_next;
    logic [SET_WIDTH-1:0]            cand_reg, cand_next;
    logic [CMP_W-1:0]                start_reg, start_next;
    logic [CMP_W-1:0]                idx_reg, idx_next;      // one above entry index
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [CNT_W-1:0]                removed_reg, removed_next;
    logic                            culling_reg, culling_next;
    logic                            done_reg, done_next;
    logic [mbf_pkg::OUTCOME_W-1:0]   outcome_reg, outcome_next;
    logic [mbf_pkg::COUNT_W-1:0]     rem_out_reg, rem_out_next;
    logic [mbf_pkg::COUNT_W-1:0]     cnt_out_reg, cnt_out_next;

    // table port signals
    logic                            wr_en;
    logic [ADDR_W-1:0]               wr_addr;
    logic [SET_WIDTH-1:0]            wr_data;
    logic [ADDR_W-1:0]               rd_addr;
    logic [SET_WIDTH-1:0]            rd_data;
    mbf_pkg::subset_flags_t          flags;

    // extended views for compares
    logic [CMP_W-1:0]                count_cmp;
    logic [CMP_W-1:0]                end_cmp;
    logic [CMP_W-1:0]                idx_dec;
    logic [CNT_W-1:0]                count_dec;
    logic [OUT_W-1:0]                count_out_ext;
    logic [OUT_W-1:0]                removed_out_ext;

    assign count_cmp = CMP_W'(count_reg);
    assign end_cmp   = CMP_W'(window_end);
    assign idx_dec   = idx_reg - CMP_W'(1);
    assign count_dec = count_reg - CNT_W'(1);

    // table and shared compare unit
    mbf_table #(
        .SET_WIDTH   (SET_WIDTH),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mbf_subset_unit #(
        .SET_WIDTH (SET_WIDTH)
    ) u_subset (
        .cand  (cand_reg),
        .entry (rd_data),
        .flags (flags)
    );

    // read address: the last entry during the compare, for a possible removal,
    // else the entry under the walk pointer
    assign rd_addr = (state_reg == ST_COMPARE) ? count_dec[ADDR_W-1:0]
                                               : idx_dec[ADDR_W-1:0];

    // table writes: moved entry into a removed slot, or candidate append
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_dec[ADDR_W-1:0];
        wr_data = rd_data;
        if (state_reg == ST_MOVE)
        begin
            wr_en = 1'b1;
        end
        else if (state_reg == ST_APPEND && count_reg < CNT_W'(TABLE_DEPTH))
        begin
            wr_en   = 1'b1;
            wr_addr = count_reg[ADDR_W-1:0];
            wr_data = cand_reg;
        end
    end

    // count views for the result fields, reported modulo 128
    assign count_out_ext   = OUT_W'(count_next);
    assign removed_out_ext = OUT_W'(removed_next);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        cand_next    = cand_reg;
        start_next   = start_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        removed_next = removed_reg;
        culling_next = culling_reg;
        done_next    = 1'b0;
        outcome_next = outcome_reg;
        rem_out_next = rem_out_reg;
        cnt_out_next = cnt_out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cand_next    = candidate_set[SET_WIDTH-1:0];
                    start_next   = CMP_W'(window_start);
                    // clamp the window end to the entry count
                    idx_next     = (end_cmp > count_cmp) ? count_cmp : end_cmp;
                    removed_next = '0;
                    culling_next = 1'b0;
                    state_next   = ST_LOOP;
                end
            end
            ST_LOOP:
            begin
                if (idx_reg > start_reg)
                begin
                    if (idx_reg > count_cmp)
                    begin
                        // entry lies beyond a shrunken table
                        idx_next = idx_dec;
                    end
                    else
                    begin
                        state_next = ST_COMPARE;
                    end
                end
                else
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_COMPARE:
            begin
                if (!culling_reg && flags.cand_in_entry)
                begin
                    // candidate already covered: drop it
                    done_next    = 1'b1;
                    outcome_next = mbf_pkg::OUTCOME_SUBSET;
                    rem_out_next = '0;
                    cnt_out_next = count_out_ext[mbf_pkg::COUNT_W-1:0];
                    state_next   = ST_IDLE;
                end
                else if (flags.entry_in_cand)
                begin
                    state_next = ST_MOVE;
                end
                else
                begin
                    idx_next   = idx_dec;
                    state_next = ST_LOOP;
                end
            end
            ST_MOVE:
            begin
                count_next   = count_dec;
                removed_next = removed_reg + CNT_W'(1);
                culling_next = 1'b1;
                idx_next     = idx_dec;
                state_next   = ST_LOOP;
            end
            ST_APPEND:
            begin
                if (count_reg < CNT_W'(TABLE_DEPTH))
                begin
                    count_next   = count_reg + CNT_W'(1);
                    outcome_next = mbf_pkg::OUTCOME_APPEND;
                end
                else
                begin
                    outcome_next = mbf_pkg::OUTCOME_FULL;
                end
                done_next    = 1'b1;
                rem_out_next = removed_out_ext[mbf_pkg::COUNT_W-1:0];
                cnt_out_next = count_out_ext[mbf_pkg::COUNT_W-1:0];
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            done_reg    <= 1'b0;
            culling_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
            culling_reg <= culling_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        cand_reg    <= cand_next;
        start_reg   <= start_next;
        idx_reg     <= idx_next;
        removed_reg <= removed_next;
        outcome_reg <= outcome_next;
        rem_out_reg <= rem_out_next;
        cnt_out_reg <= cnt_out_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign outcome       = outcome_reg;
    assign removed_count = rem_out_reg;
    assign entry_count   = cnt_out_reg;

endmodule

`default_nettype wire

// ===== bench/maximal_bitset_filter_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maximal_bitset_filter_core_tb
// self-checking bench for the maximal bit-set filter core
// ----------------------------------------------------------------------------
// Candidates go in through the start/busy command port. A scoreboard keeps
// its own copy of the set table and the entry count. For every accepted
// transfer it predicts the outcome, the number of entries removed and the
// new count. Each done strobe is checked against the oldest prediction.
// A short directed sequence comes first: the empty table, equal sets,
// removals after a move from the table end, empty and clamped windows, and
// partial windows. Random bursts follow. They mix narrow, wide and
// table-derived candidates, and grow bursts that fill the table to full.
// ----------------------------------------------------------------------------

module maximal_bitset_filter_core_tb;

    import mbf_pkg::*;

    localparam int DEPTH        = TABLE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1380;
    localparam int TAIL_CYCLES  = 250;       // beyond the worst item latency
    localparam int CYCLE_LIMIT  = 2_000_000;

    // kinds of random burst
    typedef enum int {
        STYLE_NARROW,    // few adjacent bits, many subset relations
        STYLE_DERIVED,   // built from sets already in the table
        STYLE_GROW,      // empty window, so every candidate is appended unless the table is full
        STYLE_WIDE       // full-width random sets
    } stim_style_t;

    // ------------------------------------------------------------------------
    // scoreboard: copy of the table plus the queue of awaited results
    // ------------------------------------------------------------------------
    class filter_scoreboard;

        typedef struct packed {
            logic [OUTCOME_W-1:0] outcome;
            logic [COUNT_W-1:0]   removed;
            logic [COUNT_W-1:0]   entries;
        } filter_result_t;

        logic [CAND_W-1:0] kept_sets [TABLE_DEPTH_DEF];
        int unsigned       kept_count;
        filter_result_t    awaited_results [$];
        int unsigned       fail_count;

        function new();
            kept_count = 0;
            fail_count = 0;
        endfunction

        task report(string msg);
            $display("%0t ns: %s", $time, msg);
            fail_count++;
        endtask

        function int unsigned pending();
            return awaited_results.size();
        endfunction

        // walk the window top down, as the core does, and update the table
        function void note_candidate(logic [CAND_W-1:0] cand, logic [WINDOW_W-1:0] lo,
                                     logic [WINDOW_W-1:0] hi);
            filter_result_t res;
            int unsigned    slot;
            int unsigned    removed;
            bit             culling;
            bit             subsumed;
            slot     = (hi > kept_count) ? kept_count : hi;
            removed  = 0;
            culling  = 1'b0;
            subsumed = 1'b0;
            while (slot > lo && !subsumed)
            begin
                slot--;
                if (slot < kept_count)
                begin
                    // once culling has begun the candidate can no longer be dropped
                    if (!culling && (cand & ~kept_sets[slot]) == '0)
                    begin
                        subsumed = 1'b1;
                    end
                    else if ((kept_sets[slot] & ~cand) == '0)
                    begin
                        // last entry moves into the freed slot and is not looked at
                        kept_sets[slot] = kept_sets[kept_count - 1];
                        kept_count--;
                        removed++;
                        culling = 1'b1;
                    end
                end
            end
            if (subsumed)
            begin
                res.outcome = OUTCOME_SUBSET;
                res.removed = '0;
            end
            else if (kept_count >= DEPTH)
            begin
                res.outcome = OUTCOME_FULL;
                res.removed = COUNT_W'(removed);
            end
            else
            begin
                kept_sets[kept_count] = cand;
                kept_count++;
                res.outcome = OUTCOME_APPEND;
                res.removed = COUNT_W'(removed);
            end
            res.entries = COUNT_W'(kept_count);
            awaited_results.insert(awaited_results.size(), res);
        endfunction

        task check_result(logic [OUTCOME_W-1:0] outcome, logic [COUNT_W-1:0] removed,
                          logic [COUNT_W-1:0] entries);
            filter_result_t want;
            if (awaited_results.size() == 0)
            begin
                report($sformatf("unexpected result: outcome %0d removed %0d count %0d",
                                 outcome, removed, entries));
                return;
            end
            want = awaited_results.pop_front();
            if (outcome !== want.outcome)
                report($sformatf("outcome differs: got %0d, want %0d",
                                 outcome, want.outcome));
            if (removed !== want.removed)
                report($sformatf("removed_count differs: got %0d, want %0d",
                                 removed, want.removed));
            if (entries !== want.entries)
                report($sformatf("entry_count differs: got %0d, want %0d",
                                 entries, want.entries));
        endtask

    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  start         = 1'b0;
    logic [CAND_W-1:0]     candidate_set = '0;
    logic [WINDOW_W-1:0]   window_start  = '0;
    logic [WINDOW_W-1:0]   window_end    = '0;
    logic                  busy;
    logic                  done;
    logic [OUTCOME_W-1:0]  outcome;
    logic [COUNT_W-1:0]    removed_count;
    logic [COUNT_W-1:0]    entry_count;

    filter_scoreboard sb = new();
    bit               idle_on = 1'b1;    // cleared for bursts without gaps
    int unsigned      cycle_count = 0;

    always #1 clk = ~clk;

    maximal_bitset_filter_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .candidate_set (candidate_set),
        .window_start  (window_start),
        .window_end    (window_end),
        .done          (done),
        .outcome       (outcome),
        .removed_count (removed_count),
        .entry_count   (entry_count)
    );

    // ------------------------------------------------------------------------
    // monitor: both sides are sampled at the rising edge, before the core's
    // registers move, so a transfer is seen exactly where the core takes it
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && busy === 1'b0)
                sb.note_candidate(candidate_set, window_start, window_end);
            if (done === 1'b1)
                sb.check_result(outcome, removed_count, entry_count);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [CAND_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly short gaps, now and then a long one
    task automatic idle_gap();
        int unsigned roll;
        int unsigned gap;
        roll = $urandom_range(0, 19);
        if (roll < 10)
            gap = 0;
        else if (roll < 17)
            gap = $urandom_range(1, 4);
        else if (roll < 19)
            gap = $urandom_range(5, 30);
        else
            gap = $urandom_range(31, 160);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // start stays high across back-to-back transfers, so it is never
    // lowered and raised in the same step
    task automatic drive_item(input logic [CAND_W-1:0] cand, input logic [WINDOW_W-1:0] lo,
                              input logic [WINDOW_W-1:0] hi);
        candidate_set <= cand;
        window_start  <= lo;
        window_end    <= hi;
        start         <= 1'b1;
        @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);
        if (idle_on)
            idle_gap();
    endtask

    function automatic logic [CAND_W-1:0] make_candidate(stim_style_t style);
        logic [CAND_W-1:0] pick;
        logic [CAND_W-1:0] base;
        int unsigned       span;
        int unsigned       shift;
        span  = $urandom_range(3, 10);
        shift = $urandom_range(0, 64 - span);
        pick  = (rand64() & ((64'd1 << span) - 1)) << shift;
        case (style)
            STYLE_WIDE:
            begin
                pick = rand64();
                if ($urandom_range(0, 1))
                    pick &= rand64();
            end
            STYLE_DERIVED:
            begin
                if (sb.kept_count > 0)
                begin
                    base = sb.kept_sets[$urandom_range(0, sb.kept_count - 1)];
                    case ($urandom_range(0, 9))
                        0, 1:    pick = base;
                        2, 3, 4: pick = base | (64'd1 << $urandom_range(0, 63));
                        5, 6:    pick = base & rand64();
                        7, 8:    pick = base | sb.kept_sets[$urandom_range(0, sb.kept_count - 1)];
                        default: pick = '1;    // clears the window unless an all-ones entry is met before any removal
                    endcase
                end
            end
            default: ;
        endcase
        return pick;
    endfunction

    function automatic void pick_window(input stim_style_t style,
                                        output logic [WINDOW_W-1:0] lo,
                                        output logic [WINDOW_W-1:0] hi);
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (style == STYLE_GROW || roll >= 17)
        begin
            // start at or above end: nothing walked
            lo = WINDOW_W'($urandom_range(0, DEPTH));
            hi = WINDOW_W'($urandom_range(0, lo));
        end
        else if (roll >= 12)
        begin
            lo = WINDOW_W'($urandom_range(0, DEPTH));
            hi = WINDOW_W'($urandom_range(lo, DEPTH));
        end
        else
        begin
            // whole table, end often above the count
            lo = '0;
            hi = WINDOW_W'($urandom_range(sb.kept_count, DEPTH));
        end
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        stim_style_t         style;
        logic [CAND_W-1:0]   cand;
        logic [WINDOW_W-1:0] lo;
        logic [WINDOW_W-1:0] hi;
        int unsigned         sent;
        int unsigned         burst_len;
        int unsigned         k;
        bit                  first_burst;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed part
        drive_item('0, 7'd0, 7'd64);                  // empty table, appended
        drive_item('0, 7'd0, 7'd64);                  // equal set, dropped
        drive_item('1, 7'd0, 7'd64);                  // swallows the empty set
        drive_item(64'd1, 7'd0, 7'd64);               // inside all ones, dropped
        drive_item(64'd1, 7'd1, 7'd1);                // empty window, appended
        drive_item(64'd1, 7'd64, 7'd0);               // start above end, appended
        drive_item(64'd3, 7'd1, 7'd64);               // two removals, end clamped
        drive_item('1, 7'd0, 7'd64);                  // removals keep going after culling
        for (k = 0; k < 4; k++)
            drive_item(64'd1 << k, 7'd1, 7'd64);      // singletons beside all ones
        drive_item(64'd5, 7'd1, 7'd64);               // removals with moves from the end
        drive_item(64'd1 << 63, 7'd0, 7'd64);         // top bit, inside all ones
        drive_item(64'h8000_0000_0000_0001, 7'd1, 7'd2);  // partial window, appended
        drive_item(64'd1 << 3, 7'd0, 7'd3);           // equal entry inside a partial window
        drive_item('1, 7'd2, 7'd64);                  // window above the bottom entries

        // random part: the first burst fills the table so it runs full early
        sent        = 0;
        first_burst = 1'b1;
        while (sent < RANDOM_ITEMS)
        begin
            if (first_burst)
            begin
                style     = STYLE_GROW;
                burst_len = DEPTH + 8;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2:    style = STYLE_NARROW;
                    3, 4, 5, 6: style = STYLE_DERIVED;
                    7:          style = STYLE_GROW;
                    default:    style = STYLE_WIDE;
                endcase
                burst_len = $urandom_range(8, 60);
            end
            first_burst = 1'b0;
            idle_on     = ($urandom_range(0, 3) != 0);
            for (k = 0; k < burst_len && sent < RANDOM_ITEMS; k++)
            begin
                cand = make_candidate(style);
                pick_window(style, lo, hi);
                drive_item(cand, lo, hi);
                sent++;
            end
        end

        start <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));

        if (sb.fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
